/* rtl/assert_macros.svh */
// Assertion macros used by the escape decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CESD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CESD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/cesd_pkg.sv */
// Types, character codes and helper functions for the escape decoder.
`default_nettype none

package cesd_pkg;

  localparam int unsigned MaxRes = 6;

  localparam logic [15:0] CHAR_BSL = 16'h005C;
  localparam logic [15:0] CHAR_X   = 16'h0078;
  localparam logic [15:0] CHAR_U   = 16'h0075;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BSL  = 4'b0010,
    PH_HEX2 = 4'b0100,
    PH_HEX4 = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [1:0]      digits;
    logic [2:0][6:0] held;
  } cesd_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][15:0] chars;
    logic [2:0]              count;
  } cesd_res_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] ch;
  } esc_map_t;

  function automatic logic hex_char(logic [15:0] c);
    return (c >= 16'h0030 && c <= 16'h0039) ||
           (c >= 16'h0041 && c <= 16'h0046) ||
           (c >= 16'h0061 && c <= 16'h0066);
  endfunction

  // Valid only for ASCII hex digits: letters carry bit 6.
  function automatic logic [3:0] hex_val(logic [6:0] a);
    return a[6] ? (a[3:0] + 4'd9) : a[3:0];
  endfunction

  function automatic esc_map_t simple_esc(logic [15:0] c);
    esc_map_t m;
    m.hit = 1'b1;
    m.ch  = c;
    unique case (c) inside
      16'h006E: m.ch = 16'h000A;
      16'h0072: m.ch = 16'h000D;
      16'h0074: m.ch = 16'h0009;
      16'h0061: m.ch = 16'h0007;
      16'h0062: m.ch = 16'h0008;
      16'h0066: m.ch = 16'h000C;
      16'h0076: m.ch = 16'h000B;
      16'h0027, 16'h0022, 16'h003F, CHAR_BSL: m.ch = c;
      default:  m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/cesd_decode.sv */
// Next-state and result-list logic for one character of the escape decoder.
`default_nettype none

module cesd_decode (
  input  cesd_pkg::cesd_state_t st_i,
  input  logic [15:0]           char_i,
  input  logic                  end_i,
  output cesd_pkg::cesd_state_t st_o,
  output cesd_pkg::cesd_res_t   res_o
);
  import cesd_pkg::*;

  cesd_state_t             nxt;
  logic [MaxRes-1:0][15:0] list;
  logic [2:0]              n;
  esc_map_t                esc;
  logic                    is_hex;
  logic [1:0]              dig_inc;

  always_comb begin
    nxt     = st_i;
    list    = '0;
    n       = 3'd0;
    esc     = simple_esc(char_i);
    is_hex  = hex_char(char_i);
    dig_inc = st_i.digits + 2'd1;

    unique case (st_i.phase) inside
      PH_IDLE: begin
        if (char_i == CHAR_BSL) begin
          nxt.phase = PH_BSL;
        end else begin
          list[n] = char_i;
          n = n + 3'd1;
        end
      end
      PH_BSL: begin
        nxt.digits = 2'd0;
        if (esc.hit) begin
          list[n] = esc.ch;
          n = n + 3'd1;
          nxt.phase = PH_IDLE;
        end else if (char_i == CHAR_X) begin
          nxt.phase = PH_HEX2;
        end else if (char_i == CHAR_U) begin
          nxt.phase = PH_HEX4;
        end else begin
          list[n] = CHAR_BSL;
          n = n + 3'd1;
          list[n] = char_i;
          n = n + 3'd1;
          nxt.phase = PH_IDLE;
        end
      end
      PH_HEX2, PH_HEX4: begin
        if (is_hex) begin
          if (st_i.phase == PH_HEX2 && st_i.digits == 2'd1) begin
            list[n] = {8'h00, hex_val(st_i.held[0]), hex_val(char_i[6:0])};
            n = n + 3'd1;
            nxt.phase  = PH_IDLE;
            nxt.digits = 2'd0;
          end else if (st_i.phase == PH_HEX4 && st_i.digits == 2'd3) begin
            list[n] = {hex_val(st_i.held[0]), hex_val(st_i.held[1]),
                       hex_val(st_i.held[2]), hex_val(char_i[6:0])};
            n = n + 3'd1;
            nxt.phase  = PH_IDLE;
            nxt.digits = 2'd0;
          end else begin
            nxt.held[st_i.digits] = char_i[6:0];
            nxt.digits = dig_inc;
          end
        end else begin
          // Broken hex escape: give back what was held, then treat char as fresh.
          list[n] = CHAR_BSL;
          n = n + 3'd1;
          list[n] = (st_i.phase == PH_HEX2) ? CHAR_X : CHAR_U;
          n = n + 3'd1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < st_i.digits) begin
              list[n] = {9'h000, st_i.held[i]};
              n = n + 3'd1;
            end
          end
          nxt.digits = 2'd0;
          if (char_i == CHAR_BSL) begin
            nxt.phase = PH_BSL;
          end else begin
            nxt.phase = PH_IDLE;
            list[n] = char_i;
            n = n + 3'd1;
          end
        end
      end
      default: begin
        nxt.phase  = PH_IDLE;
        nxt.digits = 2'd0;
      end
    endcase

    // End of text: drain anything still held.
    if (end_i) begin
      if (nxt.phase != PH_IDLE) begin
        list[n] = CHAR_BSL;
        n = n + 3'd1;
      end
      if (nxt.phase == PH_HEX2) begin
        list[n] = CHAR_X;
        n = n + 3'd1;
      end else if (nxt.phase == PH_HEX4) begin
        list[n] = CHAR_U;
        n = n + 3'd1;
      end
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nxt.digits) begin
          list[n] = {9'h000, nxt.held[i]};
          n = n + 3'd1;
        end
      end
      nxt.phase  = PH_IDLE;
      nxt.digits = 2'd0;
    end
  end

  assign st_o        = nxt;
  assign res_o.chars = list;
  assign res_o.count = n;

endmodule

`default_nettype wire

/* rtl/c_escape_sequence_decoder_top.sv */
// Top level of the C escape decoder: input register, decode logic, result queue.
`default_nettype none
`include "assert_macros.svh"

// Decodes C-style escapes (simple escapes, \x with two hex digits, \u with four)
// from a stream of 16-bit characters in one left-to-right pass. A request is
// taken into an input register, then decoded into a list of up to six result
// characters that is loaded into a six-entry shift queue and drains at one
// result per cycle while out_stall_i is low. A request yielding zero or one
// result does not hold off the next, so plain text and complete escapes stream
// at one request per cycle while the output does not stall; one yielding more
// (a flushed broken escape or the end of text) holds off the next request until
// its list is down to its last result. run_last marks the last result of a
// request, text_last the last result of a request with text_end set.
module c_escape_sequence_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] char_in_i,
  input  logic        text_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] char_out_o,
  output logic        run_last_o,
  output logic        text_last_o
);
  import cesd_pkg::*;

  logic                    a_valid_q, a_valid_d;
  logic [15:0]             a_char_q;
  logic                    a_end_q;
  logic                    accept;
  logic                    a_move;
  logic                    take;

  cesd_state_t             state_q, state_d;
  cesd_res_t               dec_res;

  logic [MaxRes-1:0][15:0] res_q;
  logic [2:0]              left_q, left_d;
  logic                    end_q;

  assign take        = out_valid_o && !out_stall_i;
  assign a_move      = a_valid_q && ((left_q == 3'd0) || ((left_q == 3'd1) && take));
  assign in_stall_o  = a_valid_q && !a_move;
  assign accept      = in_valid_i && !in_stall_o;
  assign a_valid_d   = accept || (a_valid_q && !a_move);

  cesd_decode u_decode (
    .st_i   (state_q),
    .char_i (a_char_q),
    .end_i  (a_end_q),
    .st_o   (state_d),
    .res_o  (dec_res)
  );

  always_comb begin
    left_d = left_q;
    if (a_move) begin
      left_d = dec_res.count;
    end else if (take) begin
      left_d = left_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q      <= 1'b0;
      left_q         <= 3'd0;
      state_q.phase  <= PH_IDLE;
      state_q.digits <= 2'd0;
      state_q.held   <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      left_q    <= left_d;
      if (a_move) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_char_q <= char_in_i;
      a_end_q  <= text_end_i;
    end
    if (a_move) begin
      res_q        <= dec_res.chars;
      end_q        <= a_end_q;
    end else if (take) begin
      // Advance the queue by one result.
      res_q <= {16'h0000, res_q[MaxRes-1:1]};
    end
  end

  assign out_valid_o = left_q != 3'd0;
  assign char_out_o  = res_q[0];
  assign run_last_o  = left_q == 3'd1;
  assign text_last_o = run_last_o && end_q;

  `CESD_ASSERT(a_text_last_run, text_last_o |-> run_last_o, "text_last without run_last")
  `CESD_ASSERT(a_digits_phase,
      (state_q.digits != 2'd0) |-> (state_q.phase == PH_HEX2 || state_q.phase == PH_HEX4),
      "hex digits held outside a hex escape")
  `CESD_ASSERT(a_hex2_digits, (state_q.phase == PH_HEX2) |-> (state_q.digits <= 2'd1),
      "too many digits held in a two-digit escape")
  `CESD_ASSERT(a_state_hold, !a_move |=> $stable(state_q.phase) && $stable(state_q.digits),
      "decoder state changed without a request")
  `CESD_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o && $stable(left_q),
      "stalled result queue changed")
  `CESD_ASSERT_NEVER(a_left_range, left_q > 3'd6, "result queue count out of range")

endmodule

`default_nettype wire
